[hw/rtl/gbc_pkg.sv]
package gbc_pkg;

   localparam int AVERAGE_COUNT = 100;
   localparam int DIV_L         = $clog2(AVERAGE_COUNT);
   localparam int SUM_W         = 17 + DIV_L;
   localparam int MAG_W         = 16 + DIV_L;
   localparam int RECIP_W       = 17 + DIV_L;
   localparam int PROD_W        = MAG_W + RECIP_W;
   localparam int DIV_SHIFT     = 16 + 2 * DIV_L;
   localparam int AVG_W         = $clog2(AVERAGE_COUNT + 1);

   localparam longint unsigned RECIP_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(AVERAGE_COUNT) - 64'd1) / 64'(AVERAGE_COUNT);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   localparam int NUM_AXES   = 3;
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] MODE_RUN  = 2'd0;
   localparam logic [1:0] MODE_WAIT = 2'd1;
   localparam logic [1:0] MODE_AVG  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_X     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_QUIET_LIMIT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_QUIET_NEEDED = 3'd4;

   localparam logic [14:0] QUIET_LIMIT_RESET  = 15'd5;
   localparam logic [7:0]  QUIET_NEEDED_RESET = 8'd30;

   localparam logic [15:0] RESET_OFFSET [NUM_AXES] = '{16'hFF90, 16'h0065, 16'h0004};

   typedef struct packed {
      logic item;
      logic restart;
      logic read_ok;
      logic check;
      logic accum;
      logic clear_sum;
      logic div_mag;
      logic div_mul;
      logic div_load;
   } gbc_lane_ctl_type;

endpackage

[hw/rtl/gbc_lane.sv]
module gbc_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  gbc_pkg::gbc_lane_ctl_type ctl,
   input  logic [15:0]               raw,
   input  logic [14:0]               quiet_limit,
   input  logic                      csr_load,
   input  logic [15:0]               csr_value,
   input  logic [15:0]               reset_offset,
   output logic [16:0]               rate,
   output logic                      quiet
);
   import gbc_pkg::*;

   logic [15:0]        held_ff, held_in;
   logic [15:0]        prev_ff, prev_in;
   logic [15:0]        offset_ff, offset_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [MAG_W-1:0]   mag_ff;
   logic               neg_ff, neg2_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [15:0]        used, diff, quot;
   logic [16:0]        diff_ext, lim_ext;

   assign used     = ctl.read_ok ? raw : held_ff;
   assign rate     = {used[15], used} - {offset_ff[15], offset_ff};
   assign diff     = used - prev_ff;
   assign diff_ext = {diff[15], diff};
   assign lim_ext  = {2'b00, quiet_limit};
   assign quiet    = ($signed(diff_ext) <= $signed(lim_ext)) &&
                     ($signed(diff_ext) >= -$signed(lim_ext));
   assign quot     = prod_ff[DIV_SHIFT +: 16];

   always_comb begin
      held_in   = held_ff;
      prev_in   = prev_ff;
      sum_in    = sum_ff;
      offset_in = offset_ff;
      if (ctl.item && ctl.read_ok) begin
         held_in = raw;
      end
      if (ctl.restart) begin
         prev_in = '0;
         sum_in  = '0;
      end else if (ctl.item && ctl.check) begin
         prev_in = used;
         if (ctl.clear_sum) begin
            sum_in = '0;
         end
      end else if (ctl.item && ctl.accum) begin
         sum_in = sum_ff + {{(SUM_W-16){used[15]}}, used};
      end
      if (csr_load) begin
         offset_in = csr_value;
      end else if (ctl.div_load) begin
         offset_in = neg2_ff ? 16'(-quot) : quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         prev_ff   <= '0;
         sum_ff    <= '0;
         offset_ff <= reset_offset;
      end else begin
         held_ff   <= held_in;
         prev_ff   <= prev_in;
         sum_ff    <= sum_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.div_mag) begin
         neg_ff <= sum_ff[SUM_W-1];
         mag_ff <= sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
      end
      if (ctl.div_mul) begin
         neg2_ff <= neg_ff;
         prod_ff <= PROD_W'(mag_ff) * PROD_W'(RECIP);
      end
   end

endmodule

[hw/rtl/gyro_bias_calibration_unit.sv]
// Gyro bias calibration: each sample word on req is corrected by the per-axis offsets
// in effect before it and returned on rsp, one word per cycle while req is not held off.
// A restart word starts calibration: the unit waits for quiet_needed still samples (not
// necessarily in a row), averages the next AVERAGE_COUNT samples on three parallel axis
// lanes, and loads the truncated mean as new offsets. The word that completes the average
// stalls req while the lanes run the constant divide (magnitude, reciprocal multiply,
// load); its rsp word appears together with the new offsets. req is also held off while
// a finished rsp word waits and rsp_tready is low.
module gyro_bias_calibration_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [gbc_pkg::REQ_DATA_W-1:0]   req_tdata,  // raw_x, raw_y, raw_z
   input  logic [gbc_pkg::REQ_USER_W-1:0]   req_tuser,  // func, read_ok
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gbc_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // rate_x, rate_y, rate_z, phase, cal_done
   input  logic                             csr_we,
   input  logic [gbc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [gbc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gbc_pkg::*;

   logic                  accept, busy, item, restart, final_item;
   logic [1:0]            mode_ff, mode_in;
   logic [7:0]            still_ff, still_in, still_inc;
   logic [AVG_W-1:0]      avg_ff, avg_in, avg_inc;
   logic [14:0]           quiet_limit_ff;
   logic [7:0]            quiet_needed_ff;
   logic                  div1_ff, div2_ff, div3_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [16:0]           rate_ff [NUM_AXES];
   logic [1:0]            phase_ff;
   logic                  done_ff;
   logic [16:0]           lane_rate [NUM_AXES];
   logic [NUM_AXES-1:0]   lane_quiet;
   logic                  all_quiet, clear_sum;
   gbc_lane_ctl_type      lane_ctl;

   assign busy       = div1_ff | div2_ff | div3_ff;
   assign req_tready = (!rsp_valid_ff || rsp_tready) && !busy;
   assign accept     = req_tvalid && req_tready;
   assign restart    = accept && req_tuser[0];
   assign item       = accept && !req_tuser[0];
   assign all_quiet  = &lane_quiet;
   assign still_inc  = still_ff + 8'd1;
   assign avg_inc    = avg_ff + 1'b1;

   always_comb begin
      mode_in    = mode_ff;
      still_in   = still_ff;
      avg_in     = avg_ff;
      clear_sum  = 1'b0;
      final_item = 1'b0;
      if (restart) begin
         mode_in  = MODE_WAIT;
         still_in = '0;
         avg_in   = '0;
      end else if (item) begin
         case (mode_ff)
            MODE_WAIT: begin
               if (all_quiet) begin
                  still_in = still_inc;
                  if (still_inc >= quiet_needed_ff || still_inc == 8'd0) begin
                     mode_in   = MODE_AVG;
                     avg_in    = '0;
                     clear_sum = 1'b1;
                  end
               end
            end
            MODE_AVG: begin
               avg_in = avg_inc;
               if (avg_inc >= AVG_W'(AVERAGE_COUNT)) begin
                  mode_in    = MODE_RUN;
                  final_item = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_RUN;
            end
         endcase
      end
   end

   always_comb begin
      lane_ctl           = '0;
      lane_ctl.item      = item;
      lane_ctl.restart   = restart;
      lane_ctl.read_ok   = req_tuser[1];
      lane_ctl.check     = (mode_ff == MODE_WAIT);
      lane_ctl.accum     = (mode_ff == MODE_AVG);
      lane_ctl.clear_sum = clear_sum;
      lane_ctl.div_mag   = div1_ff;
      lane_ctl.div_mul   = div2_ff;
      lane_ctl.div_load  = div3_ff;
   end

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      gbc_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (lane_ctl),
         .raw          (req_tdata[16*i +: 16]),
         .quiet_limit  (quiet_limit_ff),
         .csr_load     (csr_we && csr_addr == CSR_OFFSET_X + CSR_ADDR_W'(i)),
         .csr_value    (csr_wdata),
         .reset_offset (RESET_OFFSET[i]),
         .rate         (lane_rate[i]),
         .quiet        (lane_quiet[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && !final_item) begin
         rsp_valid_in = 1'b1;
      end
      if (div3_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_RUN;
         still_ff        <= '0;
         avg_ff          <= '0;
         div1_ff         <= 1'b0;
         div2_ff         <= 1'b0;
         div3_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         quiet_limit_ff  <= QUIET_LIMIT_RESET;
         quiet_needed_ff <= QUIET_NEEDED_RESET;
      end else begin
         mode_ff      <= mode_in;
         still_ff     <= still_in;
         avg_ff       <= avg_in;
         div1_ff      <= accept && final_item;
         div2_ff      <= div1_ff;
         div3_ff      <= div2_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_addr == CSR_QUIET_LIMIT) begin
            quiet_limit_ff <= csr_wdata[14:0];
         end
         if (csr_we && csr_addr == CSR_QUIET_NEEDED) begin
            quiet_needed_ff <= csr_wdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            rate_ff[i] <= restart ? 17'd0 : lane_rate[i];
         end
         phase_ff <= mode_in;
         done_ff  <= final_item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, done_ff, phase_ff, rate_ff[2], rate_ff[1], rate_ff[0]};

`ifndef SYNTH
   a_done_shows_after_load: assert property (@(posedge clock) disable iff (reset)
      (accept && final_item) |-> ##4 (rsp_tvalid && rsp_tdata[53]))
      else $error("calibration result word not presented after offset load");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[52:51] != 2'd3))
      else $error("illegal phase code on rsp");

   a_done_means_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[53]) |-> (rsp_tdata[52:51] == MODE_RUN))
      else $error("cal_done with phase other than running");

   a_avg_bounded: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_AVG) |-> (avg_ff < AVG_W'(AVERAGE_COUNT)))
      else $error("average count past limit");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && final_item) |=> (!accept ##1 !accept ##1 !accept))
      else $error("word accepted during offset divide");
`endif

endmodule

[tb/sv/gyro_bias_checker.sv]
module gyro_bias_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [gbc_pkg::REQ_DATA_W-1:0] req_tdata,   // raw_x, raw_y, raw_z
   input  logic [gbc_pkg::REQ_USER_W-1:0] req_tuser,   // func, read_ok
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [gbc_pkg::RSP_DATA_W-1:0] rsp_tdata,   // rate_x, rate_y, rate_z, phase, cal_done
   input  logic                           csr_we,
   input  logic [gbc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [gbc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import gbc_pkg::*;

   typedef struct packed {
      logic               cal_done;
      logic [1:0]         phase;
      logic signed [16:0] rate_z;
      logic signed [16:0] rate_y;
      logic signed [16:0] rate_x;
   } gyro_rate_type;

   logic signed [15:0] bias       [NUM_AXES];
   logic signed [15:0] held       [NUM_AXES];
   logic signed [15:0] last_seen  [NUM_AXES];
   int                 axis_total [NUM_AXES];
   logic [14:0]        still_limit;
   logic [7:0]         still_target;
   logic [7:0]         still_seen;
   int                 avg_seen;
   logic [1:0]         cal_mode;
   gyro_rate_type      corrected_q [$];

   function automatic void clear_run();
      for (int a = 0; a < NUM_AXES; a++) begin
         last_seen[a]  = '0;
         axis_total[a] = 0;
      end
      still_seen = '0;
      avg_seen   = 0;
   endfunction

   function automatic void reset_model();
      for (int a = 0; a < NUM_AXES; a++) begin
         bias[a] = RESET_OFFSET[a];
         held[a] = '0;
      end
      still_limit  = QUIET_LIMIT_RESET;
      still_target = QUIET_NEEDED_RESET;
      clear_run();
      cal_mode = MODE_RUN;
   endfunction

   function automatic void write_reg(logic [CSR_ADDR_W-1:0] addr,
                                     logic [CSR_DATA_W-1:0] data);
      if (addr >= CSR_OFFSET_X && addr < CSR_OFFSET_X + NUM_AXES) begin
         bias[int'(addr - CSR_OFFSET_X)] = data;
      end else if (addr == CSR_QUIET_LIMIT) begin
         still_limit = data[14:0];
      end else if (addr == CSR_QUIET_NEEDED) begin
         still_target = data[7:0];
      end
   endfunction

   function automatic gyro_rate_type correct_word(logic [REQ_USER_W-1:0] user,
                                                  logic [REQ_DATA_W-1:0] data);
      gyro_rate_type      r;
      logic signed [16:0] rate [NUM_AXES];
      logic signed [15:0] step;
      logic               quiet;
      logic               done;
      int                 lim;
      rate  = '{default: '0};
      quiet = 1'b1;
      done  = 1'b0;
      lim   = still_limit;
      if (user[0]) begin
         clear_run();
         cal_mode = MODE_WAIT;
      end else begin
         for (int a = 0; a < NUM_AXES; a++) begin
            if (user[1]) held[a] = data[16*a +: 16];
            rate[a] = {held[a][15], held[a]} - {bias[a][15], bias[a]};
         end
         case (cal_mode)
            MODE_WAIT: begin
               for (int a = 0; a < NUM_AXES; a++) begin
                  step = held[a] - last_seen[a];
                  if (step > lim || step < -lim) quiet = 1'b0;
                  last_seen[a] = held[a];
               end
               if (quiet) begin
                  still_seen = still_seen + 8'd1;
                  if (still_seen >= still_target || still_seen == 8'd0) begin
                     cal_mode = MODE_AVG;
                     avg_seen = 0;
                     for (int a = 0; a < NUM_AXES; a++) axis_total[a] = 0;
                  end
               end
            end
            MODE_AVG: begin
               for (int a = 0; a < NUM_AXES; a++) axis_total[a] += held[a];
               avg_seen++;
               if (avg_seen >= AVERAGE_COUNT) begin
                  for (int a = 0; a < NUM_AXES; a++)
                     bias[a] = 16'(axis_total[a] / AVERAGE_COUNT);
                  cal_mode = MODE_RUN;
                  done     = 1'b1;
               end
            end
            default: cal_mode = MODE_RUN;
         endcase
      end
      r.rate_x   = rate[0];
      r.rate_y   = rate[1];
      r.rate_z   = rate[2];
      r.phase    = cal_mode;
      r.cal_done = done;
      return r;
   endfunction

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      gyro_rate_type want;
      gyro_rate_type got;
      if (reset) begin
         reset_model();
         corrected_q.delete();
      end else begin
         if (csr_we) write_reg(csr_addr, csr_wdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[53:0];
            if (corrected_q.size() == 0) begin
               $error("rsp word %h with no word outstanding", rsp_tdata);
               fail_count++;
            end else begin
               want = corrected_q.pop_front();
               check_field("rate_x", want.rate_x, got.rate_x);
               check_field("rate_y", want.rate_y, got.rate_y);
               check_field("rate_z", want.rate_z, got.rate_z);
               check_field("phase", want.phase, got.phase);
               check_field("cal_done", want.cal_done, got.cal_done);
            end
         end
         if (req_tvalid && req_tready)
            corrected_q.push_back(correct_word(req_tuser, req_tdata));
      end
      pending <= corrected_q.size();
   end

endmodule

[tb/sv/tb_gyro_bias_calibration_unit.sv]
module tb_gyro_bias_calibration_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import gbc_pkg::*;

   localparam logic FUNC_SAMPLE  = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LAST = '1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // raw_x, raw_y, raw_z
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // func, read_ok
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // rate_x, rate_y, rate_z, phase, cal_done
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int          fail_count;
   int          pending;
   int          sender_idle   = 18;
   int          receiver_idle = 81;
   int          hold_requests = 0;
   int          holds_served  = 0;
   int          hold_left     = 0;
   int          words_sent    = 0;
   logic [14:0] gen_limit     = QUIET_LIMIT_RESET;
   logic [7:0]  gen_needed    = QUIET_NEEDED_RESET;

   gyro_bias_calibration_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   gyro_bias_checker bias_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hold off the rsp side for a long stretch on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left    <= 64;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > receiver_idle);
      end
   end

   task automatic csr_put(input logic [CSR_ADDR_W-1:0] addr,
                          input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [15:0] ox, oy, oz, input logic [14:0] lim,
                                input logic [7:0] need);
      csr_put(CSR_OFFSET_X, ox);
      csr_put(CSR_OFFSET_X + 3'd1, oy);
      csr_put(CSR_OFFSET_X + 3'd2, oz);
      csr_put(CSR_QUIET_LIMIT, {1'($urandom), lim});
      csr_put(CSR_QUIET_NEEDED, {8'($urandom), need});
      csr_put(CSR_QUIET_NEEDED + 3'($urandom_range(1, CSR_LAST - CSR_QUIET_NEEDED)),
              16'($urandom));
      csr_we     <= 1'b0;
      gen_limit  = lim;
      gen_needed = need;
   endtask

   task automatic push_word(input logic func, input logic ok, input logic [15:0] x, y, z);
      while ($urandom_range(1, 100) <= sender_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {ok, func};
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   // restart, then a jittered run of gen_needed + AVERAGE_COUNT words or more, with jumps and misses
   task automatic calibration_run();
      logic [15:0] s [NUM_AXES];
      int          length;
      int          jit;
      int          roll;
      int          a;
      int          d;
      for (int i = 0; i < NUM_AXES; i++)
         s[i] = ($urandom_range(0, 3) == 0) ? 16'h8000 + 16'($urandom_range(0, 40)) - 16'd20
                                            : 16'($urandom);
      jit    = ($urandom_range(0, 1) == 0 || gen_limit < 64) ? gen_limit : 64;
      length = ((gen_needed == 0) ? 1 : gen_needed) + AVERAGE_COUNT + $urandom_range(0, 20);
      push_word(FUNC_RESTART, 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      repeat (length) begin
         roll = $urandom_range(0, 399);
         if (roll == 0) begin
            push_word(FUNC_RESTART, 1'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
         end else if (roll < 28) begin
            a    = $urandom_range(0, NUM_AXES - 1);
            d    = gen_limit + 1 + $urandom_range(0, 32767 - gen_limit);
            s[a] = ($urandom_range(0, 1) == 0) ? s[a] + 16'(d) : s[a] - 16'(d);
            push_word(FUNC_SAMPLE, 1'b1, s[0], s[1], s[2]);
         end else if (roll < 52) begin
            push_word(FUNC_SAMPLE, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            for (int i = 0; i < NUM_AXES; i++)
               s[i] = s[i] + 16'($urandom_range(0, 2 * jit) - jit);
            push_word(FUNC_SAMPLE, 1'b1, s[0], s[1], s[2]);
         end
      end
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(5, 15))
         push_word(($urandom_range(0, 7) == 0) ? FUNC_RESTART : FUNC_SAMPLE, 1'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic run_phase(input int send_pct, input int take_pct, input int target);
      int start;
      start         = words_sent;
      sender_idle   = send_pct;
      receiver_idle <= take_pct;
      while (words_sent - start < target) begin
         if ($urandom_range(0, 5) == 0) noise_burst();
         else calibration_run();
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      push_word(FUNC_SAMPLE, 1'b0, 16'h1234, 16'hABCD, 16'h5555);
      push_word(FUNC_SAMPLE, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      push_word(FUNC_SAMPLE, 1'b1, 16'h8000, 16'h8000, 16'h8000);
      push_word(FUNC_SAMPLE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_word(FUNC_SAMPLE, 1'b1, 16'h0000, 16'h0000, 16'h0000);
      push_word(FUNC_RESTART, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_word(FUNC_SAMPLE, 1'b1, 16'h0005, 16'hFFFB, 16'h0000);
      push_word(FUNC_SAMPLE, 1'b1, 16'h000B, 16'hFFFB, 16'h0000);
      push_word(FUNC_SAMPLE, 1'b1, 16'h0006, 16'hFFFB, 16'h0000);
      push_word(FUNC_RESTART, 1'b0, 16'h0000, 16'h0000, 16'h0000);
      push_word(FUNC_SAMPLE, 1'b1, 16'hFFFA, 16'h0000, 16'h0000);
      drain();

      load_settings(16'h8000, 16'h7FFF, 16'h0000, 15'd0, 8'd0);
      push_word(FUNC_SAMPLE, 1'b1, 16'h7FFF, 16'h8000, 16'h0000);
      push_word(FUNC_RESTART, 1'b1, 16'h0000, 16'h0000, 16'h0000);
      push_word(FUNC_SAMPLE, 1'b1, 16'h7FFF, 16'h8000, 16'h0000);
      push_word(FUNC_SAMPLE, 1'b0, 16'h5A5A, 16'hA5A5, 16'h0F0F);
      push_word(FUNC_SAMPLE, 1'b1, 16'h8000, 16'h7FFF, 16'h0001);
      drain();

      load_settings(16'($urandom), 16'($urandom), 16'($urandom), 15'h7FFF, 8'd1);
      run_phase(18, 81, 150);

      load_settings(16'($urandom), 16'($urandom), 16'($urandom), 15'd0,
                    8'($urandom_range(2, 40)));
      run_phase(81, 18, 150);

      load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                    15'($urandom_range(1, 2000)), 8'd255);
      hold_requests <= hold_requests + 1;
      run_phase(0, 0, 300);

      repeat (16) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
